// ===== rtl/q2r_pkg.sv =====
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared widths, types and helpers for the quaternion to rotation matrix core.
// ----------------------------------------------------------------------------
package q2r_pkg;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 34;
    localparam int NUM_W  = 36;
    localparam int NORM_W = 33;
    localparam int N_ENT  = 9;

    typedef logic [NORM_W-1:0]        norm_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [NUM_W-1:0]  num_t;

    // The magnitude of every numerator is bounded by the norm, so it fits NORM_W bits.
    function automatic norm_t abs_mag(input num_t v);
        num_t a;
        a = v[NUM_W-1] ? -v : v;
        return a[NORM_W-1:0];
    endfunction

endpackage

// ===== rtl/quaternion_to_rotation_matrix_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Converts a fixed-point quaternion into its 3x3 rotation matrix.
// ----------------------------------------------------------------------------
// The slave channel takes one quaternion per beat on s_tdata; the master
// channel gives the nine matrix entries of that quaternion in one beat on
// m_tdata, in the same order. Any nonzero norm is divided out, rounded to
// FRAC_BITS fraction bits, and a zero quaternion gives the identity matrix.
// The pipeline has four stages for the input register, the products, the
// sums and the numerators, then one restoring divider stage per quotient bit
// and a rounding stage. One beat is taken per cycle unless the output stalls;
// nine divider lanes run side by side.
// A synchronous active-low reset clears all valid bits; data registers keep
// their contents. When the receiver holds m_tready low with a beat waiting,
// the whole pipeline holds and s_tready falls in the same cycle, so no beat
// is lost or repeated; bubbles in the pipeline are not squeezed out.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    input  logic [63:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, 16 bits each from the lowest bit
    output logic [143:0] m_tdata
);

    localparam int LANE_LAT = FRAC_BITS + 2;
    localparam int DEPTH    = 4 + LANE_LAT;
    localparam int OW       = q2r_pkg::OUT_W;
    localparam logic [OW-1:0] ONE_OUT = OW'(64'd1 << FRAC_BITS);

    logic en;
    logic vld_reg [0:DEPTH-1];

    assign m_tvalid = vld_reg[DEPTH-1];
    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    logic signed [15:0] w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= s_tdata[15:0];
            x_reg <= s_tdata[31:16];
            y_reg <= s_tdata[47:32];
            z_reg <= s_tdata[63:48];
        end
    end

    q2r_pkg::prod_t ww_reg, xx_reg, yy_reg, zz_reg;
    q2r_pkg::prod_t xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ww_reg <= w_reg * w_reg;
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            zz_reg <= z_reg * z_reg;
            xy_reg <= x_reg * y_reg;
            xz_reg <= x_reg * z_reg;
            yz_reg <= y_reg * z_reg;
            wx_reg <= w_reg * x_reg;
            wy_reg <= w_reg * y_reg;
            wz_reg <= w_reg * z_reg;
        end
    end

    localparam int SW = q2r_pkg::SUM_W;
    q2r_pkg::sum_t ns_reg;
    q2r_pkg::sum_t s_yz_reg, s_xz_reg, s_xy_reg;
    q2r_pkg::sum_t p01_reg, p02_reg, p10_reg, p12_reg, p20_reg, p21_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ns_reg   <= SW'(ww_reg) + SW'(xx_reg) + SW'(yy_reg) + SW'(zz_reg);
            s_yz_reg <= SW'(yy_reg) + SW'(zz_reg);
            s_xz_reg <= SW'(xx_reg) + SW'(zz_reg);
            s_xy_reg <= SW'(xx_reg) + SW'(yy_reg);
            p01_reg  <= SW'(xy_reg) - SW'(wz_reg);
            p02_reg  <= SW'(xz_reg) + SW'(wy_reg);
            p10_reg  <= SW'(xy_reg) + SW'(wz_reg);
            p12_reg  <= SW'(yz_reg) - SW'(wx_reg);
            p20_reg  <= SW'(xz_reg) - SW'(wy_reg);
            p21_reg  <= SW'(yz_reg) + SW'(wx_reg);
        end
    end

    localparam int NMW = q2r_pkg::NUM_W;
    q2r_pkg::num_t num_next [0:q2r_pkg::N_ENT-1];
    q2r_pkg::norm_t mag_reg [0:q2r_pkg::N_ENT-1];
    logic           neg_reg [0:q2r_pkg::N_ENT-1];
    q2r_pkg::norm_t n_reg;
    logic           zero_reg;

    always_comb begin
        num_next[0] = NMW'(ns_reg) - (NMW'(s_yz_reg) <<< 1);
        num_next[1] = NMW'(p01_reg) <<< 1;
        num_next[2] = NMW'(p02_reg) <<< 1;
        num_next[3] = NMW'(p10_reg) <<< 1;
        num_next[4] = NMW'(ns_reg) - (NMW'(s_xz_reg) <<< 1);
        num_next[5] = NMW'(p12_reg) <<< 1;
        num_next[6] = NMW'(p20_reg) <<< 1;
        num_next[7] = NMW'(p21_reg) <<< 1;
        num_next[8] = NMW'(ns_reg) - (NMW'(s_xy_reg) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < q2r_pkg::N_ENT; i++) begin
                mag_reg[i] <= q2r_pkg::abs_mag(num_next[i]);
                neg_reg[i] <= num_next[i][NMW-1];
            end
            n_reg    <= ns_reg[q2r_pkg::NORM_W-1:0];
            zero_reg <= (ns_reg == '0);
        end
    end

    logic signed [OW-1:0] ent [0:q2r_pkg::N_ENT-1];

    for (genvar e = 0; e < q2r_pkg::N_ENT; e++) begin : g_lane
        q2r_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .en      (en),
            .num_mag (mag_reg[e]),
            .norm    (n_reg),
            .neg     (neg_reg[e]),
            .entry   (ent[e])
        );
    end

    logic zdly_reg [0:LANE_LAT-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            zdly_reg[0] <= zero_reg;
            for (int i = 1; i < LANE_LAT; i++) begin
                zdly_reg[i] <= zdly_reg[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < q2r_pkg::N_ENT; i++) begin
            if (zdly_reg[LANE_LAT-1]) begin
                m_tdata[i*OW +: OW] = (i == 0 || i == 4 || i == 8) ? ONE_OUT : '0;
            end else begin
                m_tdata[i*OW +: OW] = ent[i];
            end
        end
    end

`ifndef SYNTH
    a_ready_follows_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("s_tready does not follow the output stall");

    a_reset_clears_out : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set right after reset");

    a_diag_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && FRAC_BITS <= 14) |->
            ($signed(m_tdata[15:0]) <= $signed(17'(ONE_OUT)) &&
             $signed(m_tdata[15:0]) >= -$signed(17'(ONE_OUT))))
        else $error("m00 outside [-1, 1]");
`endif

endmodule

// ===== rtl/q2r_div_lane.sv =====
// ----------------------------------------------------------------------------
// q2r_div_lane
// Pipelined restoring divider for one matrix entry: one quotient bit per
// stage, then round to nearest with ties away from zero, clamp and sign.
// ----------------------------------------------------------------------------
module q2r_div_lane #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          en,
    input  q2r_pkg::norm_t                num_mag,
    input  q2r_pkg::norm_t                norm,
    input  logic                          neg,
    output logic signed [q2r_pkg::OUT_W-1:0] entry
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = q2r_pkg::NORM_W;
    localparam logic [QW:0] ONE = (QW+1)'(1) << FRAC_BITS;

    logic [NW-1:0] rem_reg  [0:FRAC_BITS];
    logic [QW-1:0] q_reg    [0:FRAC_BITS];
    logic [NW-1:0] n_reg    [0:FRAC_BITS];
    logic          neg_reg  [0:FRAC_BITS];
    logic signed [q2r_pkg::OUT_W-1:0] entry_reg;

    logic          bit0;
    logic [NW-1:0] rem0_next;

    assign bit0      = (num_mag >= norm);
    assign rem0_next = bit0 ? (num_mag - norm) : num_mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem0_next;
            q_reg[0]   <= {{(QW-1){1'b0}}, bit0};
            n_reg[0]   <= norm;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [NW:0]   sh;
        logic          qb;
        logic [NW:0]   diff;
        logic [NW-1:0] rem_next;

        assign sh       = {rem_reg[k-1], 1'b0};
        assign qb       = (sh >= {1'b0, n_reg[k-1]});
        assign diff     = sh - {1'b0, n_reg[k-1]};
        assign rem_next = qb ? diff[NW-1:0] : sh[NW-1:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= {q_reg[k-1][QW-2:0], qb};
                n_reg[k]   <= n_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    logic [NW:0]             sh_last;
    logic                    rnd;
    logic [QW:0]             qr;
    logic [QW:0]             qc;
    logic signed [QW+1:0]    val;
    logic signed [q2r_pkg::OUT_W-1:0] entry_next;

    always_comb begin
        sh_last    = {rem_reg[FRAC_BITS], 1'b0};
        rnd        = (sh_last >= {1'b0, n_reg[FRAC_BITS]});
        qr         = {1'b0, q_reg[FRAC_BITS]} + {{QW{1'b0}}, rnd};
        qc         = (qr > ONE) ? ONE : qr;
        val        = neg_reg[FRAC_BITS] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        entry_next = q2r_pkg::OUT_W'(val);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
